// ===== src/mabs_pkg.sv =====
// Package: types, constants and state codes for the min-area split search.
package mabs_pkg;

	localparam int MaxPoints = 256;
	localparam int AddrW = $clog2(MaxPoints);
	localparam int CntW = $clog2(MaxPoints + 1);

	localparam logic [2:0] KindUpper = 3'd3;
	localparam logic [2:0] KindLower = 3'd4;
	localparam logic [2:0] KindWhole = 3'd5;

	typedef struct packed {
		logic signed [15:0] x_coord;
		logic signed [15:0] y_coord;
		logic signed [15:0] z_coord;
		logic               final_point;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic               direction;
		logic signed [15:0] cut_u;
		logic signed [15:0] cut_v;
		logic [32:0]        split_area;
		logic signed [15:0] low_x;
		logic signed [15:0] low_y;
		logic signed [15:0] low_z;
		logic signed [15:0] high_x;
		logic signed [15:0] high_y;
		logic signed [15:0] high_z;
		logic               end_of_run;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_LOAD,   // taking points
		ST_FACE,   // sweep for whole-face box of the plane
		ST_CUT,    // sweep for one candidate cut
		ST_AREA1,  // multiply the two side extents
		ST_AREA2,  // sum and compare
		ST_PLANE,  // emit plane result
		ST_BOX,    // sweep for one output box
		ST_BOXOUT  // emit box result
	} state_t;

	typedef struct packed {
		logic         clr_acc;   // reset box accumulators
		logic         acc_en;    // fold the current read point in
		logic [1:0]   mode;      // 0 face, 1 cut, 2 box
		logic [1:0]   plane;
		logic         dir;
		logic [AddrW-1:0] k;     // cut point index
		logic         t_valid;   // a read point is on the data bus
		logic [AddrW-1:0] t;     // index of the point on the bus
		logic         load_k;    // latch the cut point from the bus
		logic         mul;
		logic         cmp;
		logic         set_face;
		logic         plane_done;
		logic         box_start;
		logic [1:0]   group;     // 0 upper, 1 lower, 2 whole
	} cmd_t;

	typedef struct packed {
		logic face_empty;
	} sts_t;

	function automatic logic signed [15:0] pick(input logic [47:0] p, input logic [1:0] a);
		unique case (a)
			2'd0: pick = p[47:32];
			2'd1: pick = p[31:16];
			default: pick = p[15:0];
		endcase
	endfunction

	function automatic logic [1:0] axis_u(input logic [1:0] pl);
		axis_u = (pl == 2'd2) ? 2'd1 : 2'd0;
	endfunction

	function automatic logic [1:0] axis_v(input logic [1:0] pl);
		axis_v = (pl == 2'd0) ? 2'd1 : 2'd2;
	endfunction

endpackage

// ===== src/min_area_bbox_split_search.sv =====
// Top level: min-area split search over a loaded 3D point set.
//  channel | dir | payload    | handshake
//  in      | in  | in_item_t  | in_valid / in_ready
//  out     | out | out_item_t | out_valid / out_ready
// Points load one per cycle while in the load state. After the final point each
// plane takes a face sweep plus area steps, then 2N cuts, each swept through
// the single memory read port; then comes one box sweep per output box. Six results
// follow, each held until taken. Reset returns to loading with no points.
module min_area_bbox_split_search
	import mabs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic             wr_en, rd_en;
	logic [AddrW-1:0] wr_addr, rd_addr;
	cmd_t             cmd;
	sts_t             sts;

	mabs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_final(in_item.final_point),
		.out_valid, .out_ready, .wr_en, .wr_addr, .rd_en, .rd_addr, .cmd, .sts
	);

	mabs_datapath u_dp (
		.clk, .arst_n, .wr_en, .wr_addr,
		.wr_data({in_item.x_coord, in_item.y_coord, in_item.z_coord}),
		.rd_en, .rd_addr, .cmd, .sts, .res(out_item)
	);

endmodule

// ===== src/mabs_datapath.sv =====
// Datapath: point memory, box accumulators, area multiply and best tracking.
module mabs_datapath
	import mabs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [AddrW-1:0]     wr_addr,
	input  logic [47:0]          wr_data,
	input  logic                 rd_en,
	input  logic [AddrW-1:0]     rd_addr,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output out_item_t            res
);

	logic [47:0] mem [MaxPoints];
	logic [47:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	logic signed [15:0] ku_q, kv_q, pu, pv, cu_q, cv_q;
	// side accumulators: [0] lower, [1] upper; u,v bounds; empty flag
	logic signed [15:0] lu_q [2], hu_q [2], lv_q [2], hv_q [2];
	logic [1:0]         ne_q;
	logic signed [15:0] bl_q [3], bh_q [3];
	logic [33:0]        best_q, pa_q [3];
	logic [31:0]        m0_q, m1_q;
	logic               bdir_q;
	logic               pdir_q [3];
	logic signed [15:0] pcu_q [3], pcv_q [3];
	logic [1:0]         bp;
	logic               s;
	logic signed [15:0] c, r;
	logic               in_box;
	// extents always lie in 0..65535, so the low 16 bits of the difference are exact
	logic [15:0]        du0, dv0, du1, dv1;

	assign pu = pick(rd_q, axis_u(cmd.plane));
	assign pv = pick(rd_q, axis_v(cmd.plane));
	assign s  = cmd.dir ? (pu > ku_q) : (pv > kv_q);

	assign du0 = 16'(hu_q[0] - lu_q[0]);
	assign dv0 = 16'(hv_q[0] - lv_q[0]);
	assign du1 = 16'(hu_q[1] - lu_q[1]);
	assign dv1 = 16'(hv_q[1] - lv_q[1]);

	always_comb begin
		bp = 2'd0;
		if (pa_q[1] < pa_q[0]) bp = 2'd1;
		if (pa_q[2] < pa_q[bp]) bp = 2'd2;
	end

	assign c = pdir_q[bp] ? pick(rd_q, axis_u(bp)) : pick(rd_q, axis_v(bp));
	assign r = pdir_q[bp] ? pcu_q[bp] : pcv_q[bp];
	always_comb begin
		unique case (cmd.group)
			2'd0: in_box = (c >= r);
			2'd1: in_box = !(c >= r);
			default: in_box = 1'b1;
		endcase
	end

	assign sts.face_empty = !ne_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q <= '0;
			for (int i = 0; i < 3; i++) begin
				pa_q[i] <= '0; pdir_q[i] <= 1'b0; pcu_q[i] <= '0; pcv_q[i] <= '0;
			end
			cu_q <= '0; cv_q <= '0; best_q <= '0; bdir_q <= 1'b0;
		end else begin
			if (cmd.load_k) begin
				ku_q <= pu; kv_q <= pv;
			end
			if (cmd.clr_acc) begin
				ne_q <= '0;
				for (int i = 0; i < 3; i++) begin
					bl_q[i] <= 16'sh7fff; bh_q[i] <= -16'sh8000;
				end
			end else if (cmd.acc_en && cmd.t_valid) begin
				if (cmd.mode == 2'd2) begin
					if (in_box) begin
						for (int i = 0; i < 3; i++) begin
							if (pick(rd_q, 2'(i)) < bl_q[i]) bl_q[i] <= pick(rd_q, 2'(i));
							if (pick(rd_q, 2'(i)) > bh_q[i]) bh_q[i] <= pick(rd_q, 2'(i));
						end
					end
				end else if (!(cmd.mode == 2'd1 && cmd.t == cmd.k)) begin
					logic sd;
					sd = (cmd.mode == 2'd1) ? s : 1'b0;
					if (!ne_q[sd] || pu < lu_q[sd]) lu_q[sd] <= pu;
					if (!ne_q[sd] || pu > hu_q[sd]) hu_q[sd] <= pu;
					if (!ne_q[sd] || pv < lv_q[sd]) lv_q[sd] <= pv;
					if (!ne_q[sd] || pv > hv_q[sd]) hv_q[sd] <= pv;
					ne_q[sd] <= 1'b1;
				end
			end
			if (cmd.mul) begin
				m0_q <= 32'(du0) * 32'(dv0);
				m1_q <= 32'(du1) * 32'(dv1);
			end
			if (cmd.set_face) begin
				best_q <= ne_q[0] ? 34'(m0_q) : '0;
				bdir_q <= 1'b0;
			end
			if (cmd.cmp && ne_q == 2'b11 && (34'(m0_q) + 34'(m1_q)) < best_q) begin
				best_q <= 34'(m0_q) + 34'(m1_q);
				bdir_q <= cmd.dir;
				cu_q   <= ku_q;
				cv_q   <= kv_q;
			end
			if (cmd.plane_done) begin
				pa_q[cmd.plane]   <= best_q;
				pdir_q[cmd.plane] <= bdir_q;
				pcu_q[cmd.plane]  <= cu_q;
				pcv_q[cmd.plane]  <= cv_q;
			end
			if (cmd.box_start) begin
				cu_q <= '0; cv_q <= '0;
			end
		end
	end

	always_comb begin
		res = '0;
		if (cmd.mode == 2'd2) begin
			res.kind = (cmd.group == 2'd0) ? KindUpper :
				(cmd.group == 2'd1) ? KindLower : KindWhole;
			res.low_x = bl_q[0]; res.low_y = bl_q[1]; res.low_z = bl_q[2];
			res.high_x = bh_q[0]; res.high_y = bh_q[1]; res.high_z = bh_q[2];
			res.end_of_run = (cmd.group == 2'd2);
		end else begin
			res.kind = {1'b0, cmd.plane};
			res.direction = bdir_q;
			res.cut_u = cu_q;
			res.cut_v = cv_q;
			res.split_area = best_q[32:0];
		end
	end

endmodule

// ===== src/mabs_ctrl.sv =====
// Controller: load, per-plane face and cut sweeps, box sweeps, output handshake.
module mabs_ctrl
	import mabs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_final,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             wr_en,
	output logic [AddrW-1:0] wr_addr,
	output logic             rd_en,
	output logic [AddrW-1:0] rd_addr,
	output cmd_t             cmd,
	input  sts_t             sts
);

	state_t state_q, state_d;
	logic [CntW-1:0]  cnt_q;
	logic [CntW-1:0]  idx_q;     // sweep read index
	logic [AddrW-1:0] k_q;
	logic [1:0]       plane_q, group_q;
	logic             dir_q, tv_q, kphase_q;
	logic [AddrW-1:0] t_q;
	logic             acc;
	logic             sweep_end;
	logic             issue;     // a memory read is launched this cycle

	assign acc = in_valid && in_ready;
	assign in_ready = (state_q == ST_LOAD);
	assign wr_en = acc && (cnt_q < CntW'(MaxPoints));
	assign wr_addr = cnt_q[AddrW-1:0];
	assign sweep_end = (idx_q == cnt_q) && !tv_q;
	assign issue = ((state_q == ST_FACE || state_q == ST_BOX) && idx_q != cnt_q) ||
		(state_q == ST_CUT && (kphase_q ? !tv_q : (idx_q != cnt_q)));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (acc && in_final) state_d = ST_FACE;
			ST_FACE:  if (sweep_end) state_d = ST_AREA1;
			ST_CUT:   if (sweep_end && !kphase_q) state_d = ST_AREA1;
			ST_AREA1: state_d = ST_AREA2;
			ST_AREA2: begin
				if ((idx_q == '1 && sts.face_empty) ||
					(dir_q && k_q == AddrW'(cnt_q - 1'b1)))
					state_d = ST_PLANE;
				else state_d = ST_CUT;
			end
			ST_PLANE: if (out_ready) state_d = (plane_q == 2'd2) ? ST_BOX : ST_FACE;
			ST_BOX:   if (sweep_end) state_d = ST_BOXOUT;
			ST_BOXOUT: if (out_ready) state_d = (group_q == 2'd2) ? ST_LOAD : ST_BOX;
			default:  state_d = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.plane = plane_q;
		cmd.dir = dir_q;
		cmd.k = k_q;
		cmd.t = t_q;
		cmd.t_valid = tv_q;
		cmd.group = group_q;
		cmd.mode = (state_q == ST_BOX || state_q == ST_BOXOUT) ? 2'd2 :
			(state_q == ST_FACE) ? 2'd0 : 2'd1;
		// accumulators start fresh before every face, cut and box sweep
		cmd.clr_acc = (state_q == ST_LOAD) || (state_q == ST_AREA2) ||
			(state_q == ST_PLANE) || (state_q == ST_BOXOUT && out_ready);
		cmd.acc_en = (state_q == ST_FACE || state_q == ST_BOX) ||
			(state_q == ST_CUT && !kphase_q);
		cmd.load_k = (state_q == ST_CUT) && kphase_q && tv_q;
		cmd.mul = (state_q == ST_AREA1);
		cmd.set_face = (state_q == ST_AREA2) && !tv_q && (idx_q == '1);
		cmd.cmp = (state_q == ST_AREA2) && !(idx_q == '1);
		cmd.plane_done = (state_q == ST_PLANE) && out_ready;
		cmd.box_start = (state_q == ST_PLANE) && out_ready && (plane_q == 2'd2);
		rd_en = 1'b1;
		rd_addr = (state_q == ST_CUT && kphase_q) ? k_q : idx_q[AddrW-1:0];
		out_valid = (state_q == ST_PLANE || state_q == ST_BOXOUT);
	end

	// idx_q all-ones after a face sweep marks "area is the face"
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD; cnt_q <= '0; idx_q <= '0; k_q <= '0;
			plane_q <= '0; group_q <= '0; dir_q <= 1'b0; tv_q <= 1'b0;
			kphase_q <= 1'b0; t_q <= '0;
		end else begin
			state_q <= state_d;
			tv_q <= issue;
			unique case (state_q)
				ST_LOAD: begin
					if (wr_en) cnt_q <= cnt_q + 1'b1;
					plane_q <= '0; group_q <= '0; idx_q <= '0; dir_q <= 1'b0;
					k_q <= '0;
				end
				ST_FACE, ST_BOX: begin
					if (idx_q != cnt_q) begin
						t_q <= idx_q[AddrW-1:0]; idx_q <= idx_q + 1'b1;
					end
					if (state_d == ST_AREA1) idx_q <= '1;
					if (state_d == ST_BOXOUT) idx_q <= '0;
				end
				ST_CUT: begin
					if (kphase_q) begin
						if (tv_q) kphase_q <= 1'b0;
					end else if (idx_q != cnt_q) begin
						t_q <= idx_q[AddrW-1:0]; idx_q <= idx_q + 1'b1;
					end
				end
				ST_AREA2: begin
					if (idx_q != '1) begin
						if (k_q == AddrW'(cnt_q - 1'b1)) begin
							k_q <= '0; dir_q <= 1'b1;
						end else k_q <= k_q + 1'b1;
					end
					idx_q <= '0;
					kphase_q <= 1'b1;
				end
				ST_PLANE: if (out_ready) begin
					plane_q <= plane_q + 1'b1; dir_q <= 1'b0; k_q <= '0; idx_q <= '0;
				end
				ST_BOXOUT: if (out_ready) begin
					group_q <= group_q + 1'b1; idx_q <= '0;
					if (group_q == 2'd2) cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== src/mabs_checker.sv =====
// Port checker for the split search, bound to the top level.
module mabs_checker
	import mabs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken during result phase");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.kind <= KindWhole)
		else $error("bad result kind");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.end_of_run == (out_item.kind == KindWhole)))
		else $error("end flag mismatch");

endmodule

bind min_area_bbox_split_search mabs_checker u_chk (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready, .out_item
);

// ===== tb/tb_min_area_bbox_split_search.sv =====
// Testbench for the min-area split search: point sets in, plane and box results checked.
module tb_min_area_bbox_split_search;
	timeunit 1ns;
	timeprecision 1ps;
	import mabs_pkg::*;

	class split_scoreboard;
		logic signed [15:0] pts[$][3];
		out_item_t pending[$];
		int errors;

		function automatic logic [33:0] box_area(int du, int dv);
			logic [33:0] a;
			a = 34'(du) * 34'(dv);
			return a;
		endfunction

		function automatic int ax(int plane, int side);
			if (side == 0) return (plane == 2) ? 1 : 0;
			return (plane == 0) ? 1 : 2;
		endfunction

		function void note_point(in_item_t it);
			logic signed [15:0] p[3];
			if (pts.size() < MaxPoints) begin
				p[0] = it.x_coord; p[1] = it.y_coord; p[2] = it.z_coord;
				pts.insert(pts.size(), p);
			end
			if (it.final_point) predict_split();
		endfunction

		function void predict_split();
			int n, cu, cv, bp, bd;
			logic [33:0] best, a, parea[3];
			int pdir[3], pu[3], pv[3];
			int lo[2][2], hi[2][2], cnt[2];
			int u, v, s, lu, hu, lv, hv;
			out_item_t o;
			n = pts.size();
			cu = 0; cv = 0;
			for (int p = 0; p < 3; p++) begin
				best = 0;
				if (n > 0) begin
					lu = pts[0][ax(p,0)]; hu = lu; lv = pts[0][ax(p,1)]; hv = lv;
					for (int t = 1; t < n; t++) begin
						u = pts[t][ax(p,0)]; v = pts[t][ax(p,1)];
						if (u < lu) lu = u;
						if (u > hu) hu = u;
						if (v < lv) lv = v;
						if (v > hv) hv = v;
					end
					best = box_area(hu - lu, hv - lv);
				end
				pdir[p] = 0;
				for (int d = 0; d < 2; d++)
					for (int k = 0; k < n; k++) begin
						cnt[0] = 0; cnt[1] = 0;
						for (int t = 0; t < n; t++) begin
							if (t == k) continue;
							u = pts[t][ax(p,0)]; v = pts[t][ax(p,1)];
							s = (d == 0) ? (v > int'(pts[k][ax(p,1)]))
								: (u > int'(pts[k][ax(p,0)]));
							if (cnt[s] == 0) begin
								lo[s][0] = u; hi[s][0] = u; lo[s][1] = v; hi[s][1] = v;
							end else begin
								if (u < lo[s][0]) lo[s][0] = u;
								if (u > hi[s][0]) hi[s][0] = u;
								if (v < lo[s][1]) lo[s][1] = v;
								if (v > hi[s][1]) hi[s][1] = v;
							end
							cnt[s]++;
						end
						if (cnt[0] == 0 || cnt[1] == 0) continue;
						a = box_area(hi[0][0] - lo[0][0], hi[0][1] - lo[0][1])
							+ box_area(hi[1][0] - lo[1][0], hi[1][1] - lo[1][1]);
						if (a < best) begin
							best = a; pdir[p] = d;
							cu = pts[k][ax(p,0)]; cv = pts[k][ax(p,1)];
						end
					end
				parea[p] = best; pu[p] = cu; pv[p] = cv;
				o = '0;
				o.kind = 3'(p);
				o.direction = 1'(pdir[p]);
				o.cut_u = 16'(cu);
				o.cut_v = 16'(cv);
				o.split_area = best[32:0];
				pending.insert(pending.size(), o);
			end
			bp = 0;
			for (int p = 1; p < 3; p++)
				if (parea[p] < parea[bp]) bp = p;
			bd = pdir[bp];
			for (int g = 0; g < 3; g++) begin
				int l[3], h[3], c, r;
				bit take;
				l = '{32767, 32767, 32767};
				h = '{-32768, -32768, -32768};
				for (int t = 0; t < n; t++) begin
					c = (bd == 0) ? pts[t][ax(bp,1)] : pts[t][ax(bp,0)];
					r = (bd == 0) ? pv[bp] : pu[bp];
					take = (g == 2) || ((c >= r) ? (g == 0) : (g == 1));
					if (!take) continue;
					for (int i = 0; i < 3; i++) begin
						if (pts[t][i] < l[i]) l[i] = pts[t][i];
						if (pts[t][i] > h[i]) h[i] = pts[t][i];
					end
				end
				o = '0;
				o.kind = (g == 0) ? KindUpper : (g == 1) ? KindLower : KindWhole;
				o.low_x = 16'(l[0]); o.low_y = 16'(l[1]); o.low_z = 16'(l[2]);
				o.high_x = 16'(h[0]); o.high_y = 16'(h[1]); o.high_z = 16'(h[2]);
				o.end_of_run = (g == 2);
				pending.insert(pending.size(), o);
			end
			pts.delete();
		endfunction

		task report(string what, out_item_t got, out_item_t want);
			$display("mismatch %s: got %p want %p", what, got, want);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				report("unexpected result", got, '0);
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind) report("kind", got, want);
			if (got.direction !== want.direction) report("direction", got, want);
			if (got.cut_u !== want.cut_u) report("cut_u", got, want);
			if (got.cut_v !== want.cut_v) report("cut_v", got, want);
			if (got.split_area !== want.split_area) report("split_area", got, want);
			if (got.low_x !== want.low_x) report("low_x", got, want);
			if (got.low_y !== want.low_y) report("low_y", got, want);
			if (got.low_z !== want.low_z) report("low_z", got, want);
			if (got.high_x !== want.high_x) report("high_x", got, want);
			if (got.high_y !== want.high_y) report("high_y", got, want);
			if (got.high_z !== want.high_z) report("high_z", got, want);
			if (got.end_of_run !== want.end_of_run) report("end_of_run", got, want);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	in_item_t in_item = '0;
	out_item_t out_item;
	split_scoreboard sb = new();
	int burst_left = 0;
	int n_sent = 0;

	min_area_bbox_split_search uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver: stall pattern with quiet stretches
	int stall_mode = 0;
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(out_item);
		if ($urandom_range(0, 40) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	function automatic logic signed [15:0] rand_coord(int style);
		case (style)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 8) - 4);
			default: return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
		endcase
	endfunction

	// valid drops only when a real gap follows the burst
	task send_point(logic signed [15:0] x, y, z, logic fin);
		int gap;
		in_item <= '{x_coord: x, y_coord: y, z_coord: z, final_point: fin};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_point('{x_coord: x, y_coord: y, z_coord: z, final_point: fin});
		n_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task send_object(int n, int style);
		for (int i = 0; i < n; i++)
			send_point(rand_coord(style), rand_coord(style), rand_coord(style), i == n - 1);
	endtask

	initial begin
		#(12 * 3000000);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int n, guard;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: single point, two points, extremes, ties, overflow of store
		send_point(16'sh0, 16'sh0, 16'sh0, 1'b1);
		send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
		send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
		for (int i = 0; i < 4; i++) send_point(16'sh10, 16'sh10, 16'sh10, i == 3);
		send_point(16'sh8000, 16'sh0, 16'sh7FFF, 1'b0);
		send_point(16'sh7FFF, 16'sh8000, 16'sh0, 1'b0);
		send_point(16'sh0, 16'sh7FFF, 16'sh8000, 1'b0);
		send_point(16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1);
		send_point(16'sh1, 16'sh2, 16'sh3, 1'b0);
		send_point(16'sh1, 16'sh2, 16'sh3, 1'b0);
		send_point(16'sh100, 16'sh2, 16'sh3, 1'b0);
		send_point(16'sh100, 16'sh200, 16'sh3, 1'b1);
		send_point(16'sh5555, -16'sh5556, 16'sh2AAA, 1'b0);
		send_point(-16'sh2AAB, 16'sh5555, -16'sh5556, 1'b1);
		send_object(MaxPoints + 3, 0);	// store full, final point dropped
		while (n_sent < 360) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			send_object(n, $urandom_range(0, 2));
		end
		in_valid <= 1'b0;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 2000000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
